FILE: src/stwe_pkg.sv
// Package for the session table with expiry: sizes, codes, request/result structs
// and the sequencer state type.
// Used by stwe_ctrl and session_table_with_expiry_core; no dependencies.
package stwe_pkg;

    localparam int SLOTS   = 128;
    localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ENTRY_W = 64;

    localparam int CFG_AW   = 2;
    localparam int IN_TDATA_W  = 136;
    localparam int OUT_TDATA_W = 72;

    localparam logic [CFG_AW-1:0] CFG_EXPECTED_VERSION = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_IDLE_TMO         = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_REPLAY_WINDOW    = 2'd2;

    localparam logic ACT_AUTH     = 1'b0;
    localparam logic ACT_VALIDATE = 1'b1;

    localparam logic [31:0] RST_EXPECTED_VERSION = 32'd1;
    localparam logic [15:0] RST_IDLE_TMO         = 16'd3600;
    localparam logic [15:0] RST_REPLAY_WINDOW    = 16'd300;
    localparam logic [31:0] RST_ID_COUNTER       = 32'd1;
    localparam logic [31:0] ID_MAX               = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_VERSION = 3'd1,
        ST_STALE   = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_FULL    = 3'd4,
        ST_EXPIRED = 3'd5,
        ST_UNKNOWN = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic        action;
        logic [31:0] now;
        logic [31:0] req_version;
        logic [31:0] request_time;
        logic        name_empty;
        logic [31:0] lookup_id;
    } t_req;

    typedef struct packed {
        logic [31:0] expected_version;
        logic [15:0] idle_tmo;
        logic [15:0] replay_window;
    } t_cfg;

    typedef struct packed {
        t_status     status;
        logic [31:0] new_id;
        logic [32:0] exp_at;
    } t_res;

    typedef struct packed {
        logic [31:0] id;
        logic [31:0] last_seen;
    } t_entry;

endpackage

FILE: src/stwe_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module stwe_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/stwe_ctrl.sv
// Request sequencer: checks, slot scan over the entry RAM, active marks and id counter.
// Depends on stwe_pkg and stwe_ram.
module stwe_ctrl
    import stwe_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_req i_req,
    input  t_cfg i_cfg,
    input  logic i_res_take,
    output logic o_ready,
    output logic o_res_vld,
    output t_res o_res
);

    localparam logic [SLOT_AW:0]   SLOTS_CNT = (SLOT_AW + 1)'(SLOTS);
    localparam logic [SLOT_AW-1:0] LAST_IDX  = SLOT_AW'(SLOTS - 1);

    t_state             r_state, n_state;
    t_req               r_req, n_req;
    logic [SLOT_AW:0]   r_idx, n_idx;
    logic               r_rd_vld, n_rd_vld;
    logic [SLOT_AW-1:0] r_rd_idx, n_rd_idx;
    logic [SLOTS-1:0]   r_active, n_active;
    logic [31:0]        r_id_cnt, n_id_cnt;
    t_res               r_res, n_res;

    t_entry             rd_entry;
    t_entry             wr_entry;
    logic               ram_we;
    logic               ram_re;

    logic [32:0]        rt_diff;
    logic [32:0]        rt_abs;
    logic               bad_version;
    logic               stale;
    logic               auth_fail;
    t_status            fail_status;

    logic               slot_act;
    logic               hit;
    logic               miss;
    logic [32:0]        idle;
    logic               expired;

    stwe_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(SLOTS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_rd_idx),
        .i_wdata(wr_entry),
        .i_re   (ram_re),
        .i_raddr(r_idx[SLOT_AW-1:0]),
        .o_rdata(rd_entry)
    );

    // Authenticate checks, evaluated on the latched request.
    always_comb begin
        rt_diff     = {1'b0, r_req.now} - {1'b0, r_req.request_time};
        rt_abs      = rt_diff[32] ? (33'd0 - rt_diff) : rt_diff;
        bad_version = r_req.req_version != i_cfg.expected_version;
        stale       = rt_abs > {17'd0, i_cfg.replay_window};
        auth_fail   = bad_version || stale || r_req.name_empty;
        if (bad_version) begin
            fail_status = ST_VERSION;
        end else if (stale) begin
            fail_status = ST_STALE;
        end else begin
            fail_status = ST_EMPTY;
        end
    end

    // Evaluation of the slot whose read data arrived this cycle.
    always_comb begin
        slot_act = r_active[r_rd_idx];
        idle     = {1'b0, r_req.now} - {1'b0, rd_entry.last_seen};
        expired  = !idle[32] && (idle[31:0] > {16'd0, i_cfg.idle_tmo});
        if (r_req.action == ACT_AUTH) begin
            hit = r_rd_vld && !slot_act;
        end else begin
            hit = r_rd_vld && slot_act && (rd_entry.id == r_req.lookup_id);
        end
        miss = r_rd_vld && !hit && (r_rd_idx == LAST_IDX);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if ((r_req.action == ACT_AUTH) && auth_fail) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (hit || miss) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        n_req    = r_req;
        n_idx    = r_idx;
        n_rd_vld = 1'b0;
        n_rd_idx = r_rd_idx;
        n_active = r_active;
        n_id_cnt = r_id_cnt;
        n_res    = r_res;
        ram_we   = 1'b0;
        ram_re   = 1'b0;
        wr_entry = '{id: r_id_cnt, last_seen: r_req.now};
        o_ready  = 1'b0;
        o_res_vld = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_start) begin
                    n_req = i_req;
                end
            end
            S_CHECK: begin
                n_idx = '0;
                n_res = '{status: fail_status, new_id: 32'd0, exp_at: 33'd0};
            end
            S_SCAN: begin
                ram_re   = r_idx < SLOTS_CNT;
                n_rd_idx = r_idx[SLOT_AW-1:0];
                n_rd_vld = ram_re && !hit && !miss;
                if (ram_re) begin
                    n_idx = r_idx + 1'b1;
                end
                if (hit) begin
                    if (r_req.action == ACT_AUTH) begin
                        ram_we             = 1'b1;
                        n_active[r_rd_idx] = 1'b1;
                        n_id_cnt = (r_id_cnt == ID_MAX) ? RST_ID_COUNTER : r_id_cnt + 32'd1;
                        n_res = '{status: ST_OK, new_id: r_id_cnt,
                                  exp_at: {1'b0, r_req.now}
                                          + {17'd0, i_cfg.idle_tmo}};
                    end else if (expired) begin
                        n_active[r_rd_idx] = 1'b0;
                        n_res = '{status: ST_EXPIRED, new_id: 32'd0, exp_at: 33'd0};
                    end else begin
                        ram_we   = 1'b1;
                        wr_entry = '{id: rd_entry.id, last_seen: r_req.now};
                        n_res = '{status: ST_OK, new_id: 32'd0, exp_at: 33'd0};
                    end
                end else if (miss) begin
                    if (r_req.action == ACT_AUTH) begin
                        n_res = '{status: ST_FULL, new_id: 32'd0, exp_at: 33'd0};
                    end else begin
                        n_res = '{status: ST_UNKNOWN, new_id: 32'd0, exp_at: 33'd0};
                    end
                end
            end
            S_DONE: begin
                o_res_vld = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rd_vld <= 1'b0;
            r_active <= '0;
            r_id_cnt <= RST_ID_COUNTER;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= n_rd_vld;
            r_active <= n_active;
            r_id_cnt <= n_id_cnt;
        end
        r_req    <= n_req;
        r_idx    <= n_idx;
        r_rd_idx <= n_rd_idx;
        r_res    <= n_res;
    end

    assign o_res = r_res;

`ifndef SYNTHESIS
    a_rd_vld_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_state == S_SCAN))
        else $error("read data pending outside the scan");

    a_we_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> ((r_state == S_SCAN) && hit))
        else $error("entry write without a slot hit");

    a_grant_sets_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) && hit && (r_req.action == ACT_AUTH))
        |=> r_active[$past(r_rd_idx)])
        else $error("granted slot not marked active");

    a_id_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_id_cnt != 32'd0)
        else $error("id counter reached zero");
`endif

endmodule

FILE: src/session_table_with_expiry_core.sv
// Top level of the session table with expiry: stream ports, configuration registers
// and the result register. Depends on stwe_pkg and stwe_ctrl.
//
// Channel   | Direction | Handshake                       | Payload
// ----------+-----------+---------------------------------+------------------------------
// s_axis    | in        | s_axis_tvalid / s_axis_tready   | tuser: action; tdata: request
// m_axis    | out       | m_axis_tvalid / m_axis_tready   | tdata: status, id, expiry
// cfg       | in        | i_cfg_valid / o_cfg_ready       | i_cfg_index, i_cfg_data
//
// An item whose authenticate check fails goes from the check straight to the result;
// otherwise the scan reads one entry of the slot RAM per cycle and stops at the first
// matching slot or after the last of the SLOTS slots.
// Reset is synchronous and active low; it clears the active marks and the sequencer
// and loads the register defaults, but leaves the entry RAM as it is.
// A stalled output holds the sequencer in its final state once the result register is full.
module session_table_with_expiry_core
    import stwe_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // tdata from bit 0: now[31:0], req_version[63:32], request_time[95:64],
    // name_empty[96], lookup_id[128:97], zero fill[135:129]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser: action[0]
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // tdata from bit 0: status[2:0], new_id[34:3], exp_at[67:35], zero fill[71:68]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_AW-1:0]      i_cfg_index,
    input  logic [31:0]            i_cfg_data
);

    t_cfg r_cfg;
    t_req req;
    t_res ctrl_res;
    logic ctrl_ready;
    logic ctrl_res_vld;
    logic res_take;
    logic r_out_vld;
    t_res r_out;

    // Registers are always writable; the user must write them only while the block is idle (not enforced).
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.expected_version <= RST_EXPECTED_VERSION;
            r_cfg.idle_tmo         <= RST_IDLE_TMO;
            r_cfg.replay_window    <= RST_REPLAY_WINDOW;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_EXPECTED_VERSION: r_cfg.expected_version <= i_cfg_data;
                CFG_IDLE_TMO:         r_cfg.idle_tmo         <= i_cfg_data[15:0];
                CFG_REPLAY_WINDOW:    r_cfg.replay_window    <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // Unpack the request transfer.
    assign req.action       = s_axis_tuser;
    assign req.now          = s_axis_tdata[31:0];
    assign req.req_version  = s_axis_tdata[63:32];
    assign req.request_time = s_axis_tdata[95:64];
    assign req.name_empty   = s_axis_tdata[96];
    assign req.lookup_id    = s_axis_tdata[128:97];

    assign s_axis_tready = ctrl_ready;

    stwe_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (s_axis_tvalid && ctrl_ready),
        .i_req     (req),
        .i_cfg     (r_cfg),
        .i_res_take(res_take),
        .o_ready   (ctrl_ready),
        .o_res_vld (ctrl_res_vld),
        .o_res     (ctrl_res)
    );

    // The result register takes a new result when empty or drained in this cycle.
    assign res_take = ctrl_res_vld && (!r_out_vld || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_take) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
        if (res_take) begin
            r_out <= ctrl_res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {4'd0, r_out.exp_at, r_out.new_id, r_out.status};

endmodule

FILE: tb/session_table_with_expiry_core_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for session_table_with_expiry_core: a directed table of requests,
// then random phases under several register settings, scored by an in-bench model where no result is given.
// Depends on stwe_pkg and the session_table_with_expiry_core RTL.
module session_table_with_expiry_core_tb;
    import stwe_pkg::*;

    localparam int RESET_CYCLES    = 8;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 210;
    // Long output hold-off; the block can park one request in the sequencer and one
    // result in its result register, so the input stalls well before this runs out.
    localparam int HOLD_CYCLES     = 700;
    // Slowest legal run is roughly 1700 items, each held by a full slot scan, a sender gap
    // and a sink stall; the limit leaves a wide margin on top.
    localparam int CYCLE_LIMIT     = 1_500_000;
    localparam int REPORT_MAX      = 40;
    // Index 3 has no register behind it; writes there must be dropped.
    localparam logic [CFG_AW-1:0] CFG_SPARE = 2'd3;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_AW-1:0]      i_cfg_index;
    logic [31:0]            i_cfg_data;

    // Mirror of the session table, the id counter and the registers.
    logic        live    [SLOTS];
    logic [31:0] held_id [SLOTS];
    logic [31:0] seen_at [SLOTS];
    logic [31:0] mdl_next_id;
    logic [31:0] want_version;
    logic [15:0] idle_limit;
    logic [15:0] replay_span;

    // Results still owed by the block, oldest first.
    t_res awaited_results[$];
    int   mismatch_count = 0;
    int   cycle_count = 0;

    // Sender burst state and the request for a long hold-off at the sink.
    int   burst_left = 0;
    bit   sender_steady = 1'b0;
    bit   hold_request = 1'b0;

    typedef struct {
        t_req req;
        bit   typed;
        t_res res;
    } t_stim_row;

    t_stim_row stim_rows[$];

    session_table_with_expiry_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Works out the result of one accepted request and applies its effect on the table.
    // Time differences are taken exactly in 64 bits, so nothing wraps.
    function automatic t_res serve_request(input t_req r);
        t_res   res;
        longint t_a;
        longint t_b;
        longint span;
        longint limit;
        int     hit;
        int     k;
        res.status      = ST_OK;
        res.new_id      = '0;
        res.exp_at      = '0;
        hit   = -1;
        t_a   = longint'(r.now);
        span  = longint'(replay_span);
        limit = longint'(idle_limit);
        if (r.action == ACT_AUTH) begin
            t_b = longint'(r.request_time);
            // Checks run in a fixed order: version, replay window, user name.
            if (r.req_version != want_version) begin
                res.status = ST_VERSION;
            end else if (((t_a >= t_b) ? t_a - t_b : t_b - t_a) > span) begin
                res.status = ST_STALE;
            end else if (r.name_empty) begin
                res.status = ST_EMPTY;
            end else begin
                // Walk downward so the lowest free slot wins.
                for (k = SLOTS - 1; k >= 0; k--) begin
                    if (!live[k]) hit = k;
                end
                if (hit < 0) begin
                    res.status = ST_FULL;
                end else begin
                    live[hit]       = 1'b1;
                    held_id[hit]    = mdl_next_id;
                    seen_at[hit]    = r.now;
                    res.new_id      = mdl_next_id;
                    res.exp_at      = {1'b0, r.now} + {17'd0, idle_limit};
                    // Zero is reserved for "no id", so the counter skips it on wrap.
                    mdl_next_id = (mdl_next_id == ID_MAX) ? RST_ID_COUNTER
                                                          : mdl_next_id + 32'd1;
                end
            end
        end else begin
            for (k = SLOTS - 1; k >= 0; k--) begin
                if (live[k] && held_id[k] == r.lookup_id) hit = k;
            end
            if (hit < 0) begin
                res.status = ST_UNKNOWN;
            end else begin
                t_b = longint'(seen_at[hit]);
                // A negative idle time (clock went back) never expires a session.
                if (t_a - t_b > limit) begin
                    live[hit]  = 1'b0;
                    res.status = ST_EXPIRED;
                end else begin
                    seen_at[hit] = r.now;
                end
            end
        end
        return res;
    endfunction

    // Directed rows; the expected result is given only where it is obvious.
    task automatic add_row(input logic a, input logic [31:0] t, input logic [31:0] ver,
                           input logic [31:0] rt, input logic empty, input logic [31:0] lid,
                           input bit typed, input t_status st, input logic [31:0] id,
                           input logic [32:0] exp_t);
        t_stim_row row;
        row.req.action       = a;
        row.req.now          = t;
        row.req.req_version  = ver;
        row.req.request_time = rt;
        row.req.name_empty   = empty;
        row.req.lookup_id    = lid;
        row.typed            = typed;
        row.res.status       = st;
        row.res.new_id       = id;
        row.res.exp_at       = exp_t;
        stim_rows.push_back(row);
    endtask

    // One register write; the mirror is updated at the transfer. The caller lowers
    // the valid after its last write so back-to-back writes keep it high.
    task automatic write_register(input logic [CFG_AW-1:0] index, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (index)
            CFG_EXPECTED_VERSION: want_version = data;
            CFG_IDLE_TMO:         idle_limit   = data[15:0];
            CFG_REPLAY_WINDOW:    replay_span  = data[15:0];
            default: ;
        endcase
    endtask

    // Offers one request and returns at the edge where it is taken. Bursts of random
    // length are usually separated by random gaps unless the sender runs steady.
    task automatic send_request(input t_req r);
        if (burst_left == 0) begin
            if (!sender_steady && $urandom_range(0, 3) != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.action;
        s_axis_tdata  <= {7'd0, r.lookup_id, r.name_empty, r.request_time,
                          r.req_version, r.now};
        do @(posedge i_clk); while (!s_axis_tready);
        burst_left--;
    endtask

    // Result side: scores every result transfer against the oldest expectation and
    // drives tready from a rotating stall pattern, with one long hold-off on request.
    initial begin : result_sink
        logic [31:0] sink_pattern;
        int          pattern_left;
        int          hold_left;
        t_res        oldest;
        sink_pattern  = '1;
        pattern_left  = 0;
        hold_left     = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                if (awaited_results.size() == 0) begin
                    if (mismatch_count < REPORT_MAX)
                        $display("%0t: unexpected result: status %0d id %h expiry %h",
                                 $time, m_axis_tdata[2:0], m_axis_tdata[34:3],
                                 m_axis_tdata[67:35]);
                    mismatch_count++;
                end else begin
                    oldest = awaited_results.pop_front();
                    if (oldest.status !== m_axis_tdata[2:0]
                        || oldest.new_id !== m_axis_tdata[34:3]
                        || oldest.exp_at !== m_axis_tdata[67:35]) begin
                        if (mismatch_count < REPORT_MAX)
                            $display(
                                "%0t: expected st %0d id %h exp %h, got st %0d id %h exp %h",
                                $time, oldest.status, oldest.new_id, oldest.exp_at,
                                m_axis_tdata[2:0], m_axis_tdata[34:3], m_axis_tdata[67:35]);
                        mismatch_count++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end else begin
                // A fresh 32-bit pattern once the last is used up: some are stall-free stretches,
                // the rest stall about one cycle in four.
                if (pattern_left == 0) begin
                    sink_pattern = ($urandom_range(0, 3) == 0) ? '1 : ($urandom | $urandom);
                    pattern_left = 32;
                end
                m_axis_tready <= sink_pattern[0];
                sink_pattern  = {sink_pattern[0], sink_pattern[31:1]};
                pattern_left--;
            end
        end
    end

    // A hang anywhere ends the run as a failure.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("session_table_with_expiry_core_tb failed");
        $finish;
    end

    initial begin : stimulus
        t_req        req;
        t_res        predicted;
        logic [31:0] t_now;
        logic [31:0] junk;
        logic [31:0] ver_sel;
        logic [15:0] tmo_sel;
        logic [15:0] win_sel;
        int          phase;
        int          item;
        int          roll;
        int          span;
        int          off;
        int          auth_pct;
        int          live_count;
        int          pick;
        int          k;

        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= ACT_AUTH;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= CFG_EXPECTED_VERSION;
        i_cfg_data    <= '0;

        for (k = 0; k < SLOTS; k++) begin
            live[k]    = 1'b0;
            held_id[k] = '0;
            seen_at[k] = '0;
        end
        mdl_next_id     = RST_ID_COUNTER;
        want_version    = RST_EXPECTED_VERSION;
        idle_limit      = RST_IDLE_TMO;
        replay_span     = RST_REPLAY_WINDOW;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under the reset register values (version 1, timeout 3600,
        // window 300). Failed checks take precedence in the order version, time, name.
        add_row(ACT_AUTH, 32'd1000, 32'd0, 32'd0, 1'b1, 32'd0,
                1, ST_VERSION, 32'd0, 33'd0);
        add_row(ACT_AUTH, 32'd1000, 32'hFFFF_FFFF, 32'd1000, 1'b0, 32'd0,
                1, ST_VERSION, 32'd0, 33'd0);
        // Just outside the window on either side; stale wins over an empty name.
        add_row(ACT_AUTH, 32'd1000, 32'd1, 32'd1301, 1'b1, 32'd0,
                1, ST_STALE, 32'd0, 33'd0);
        add_row(ACT_AUTH, 32'd1000, 32'd1, 32'd699, 1'b0, 32'd0,
                1, ST_STALE, 32'd0, 33'd0);
        // Extremes of the time fields: the difference must not wrap.
        add_row(ACT_AUTH, 32'd0, 32'd1, 32'hFFFF_FFFF, 1'b0, 32'd0,
                1, ST_STALE, 32'd0, 33'd0);
        add_row(ACT_AUTH, 32'hFFFF_FFFF, 32'd1, 32'd0, 1'b0, 32'd0,
                1, ST_STALE, 32'd0, 33'd0);
        // Exactly on the window edge passes the time check.
        add_row(ACT_AUTH, 32'd1000, 32'd1, 32'd700, 1'b1, 32'd0,
                1, ST_EMPTY, 32'd0, 33'd0);
        add_row(ACT_AUTH, 32'd1000, 32'd1, 32'd1300, 1'b0, 32'd0,
                1, ST_OK, 32'd1, 33'd4600);
        // Id zero is never granted.
        add_row(ACT_VALIDATE, 32'd1000, 32'd0, 32'd0, 1'b0, 32'd0,
                1, ST_UNKNOWN, 32'd0, 33'd0);
        // Idle exactly equal to the timeout still refreshes.
        add_row(ACT_VALIDATE, 32'd4600, 32'd0, 32'd0, 1'b0, 32'd1,
                1, ST_OK, 32'd0, 33'd0);
        // Clock going backwards: negative idle never expires.
        add_row(ACT_VALIDATE, 32'd0, 32'd0, 32'd0, 1'b0, 32'd1,
                1, ST_OK, 32'd0, 33'd0);
        add_row(ACT_VALIDATE, 32'd3601, 32'd0, 32'd0, 1'b0, 32'd1,
                1, ST_EXPIRED, 32'd0, 33'd0);
        add_row(ACT_VALIDATE, 32'd3601, 32'd0, 32'd0, 1'b0, 32'd1,
                1, ST_UNKNOWN, 32'd0, 33'd0);
        // Expiry time needs the 33rd bit near the top of the time range.
        add_row(ACT_AUTH, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 1'b0, 32'd0,
                1, ST_OK, 32'd2, 33'h1_0000_0E0F);
        add_row(ACT_AUTH, 32'hFFFF_FF00, 32'd1, 32'hFFFF_FE00, 1'b0, 32'd0,
                1, ST_OK, 32'd3, 33'h1_0000_0D10);
        add_row(ACT_VALIDATE, 32'd0, 32'd0, 32'd0, 1'b0, 32'd2,
                1, ST_OK, 32'd0, 33'd0);
        add_row(ACT_VALIDATE, 32'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF,
                1, ST_UNKNOWN, 32'd0, 33'd0);
        add_row(ACT_VALIDATE, 32'hFFFF_FF00, 32'd0, 32'd0, 1'b0, 32'd3,
                1, ST_OK, 32'd0, 33'd0);
        add_row(ACT_AUTH, 32'd0, 32'd1, 32'd300, 1'b0, 32'd0,
                1, ST_OK, 32'd4, 33'd3600);
        add_row(ACT_VALIDATE, 32'd3600, 32'd0, 32'd0, 1'b0, 32'd4,
                1, ST_OK, 32'd0, 33'd0);
        add_row(ACT_VALIDATE, 32'd3601, 32'd0, 32'd0, 1'b0, 32'd2,
                1, ST_EXPIRED, 32'd0, 33'd0);
        // The lookup id field is ignored on an authenticate.
        add_row(ACT_AUTH, 32'd3601, 32'd1, 32'd3601, 1'b0, 32'hFFFF_FFFF,
                0, ST_OK, 32'd0, 33'd0);
        add_row(ACT_VALIDATE, 32'd3700, 32'h1234_5678, 32'd0, 1'b1, 32'd5,
                0, ST_OK, 32'd0, 33'd0);

        // The model always runs so that its table stays in step with the block.
        foreach (stim_rows[n]) begin
            send_request(stim_rows[n].req);
            predicted = serve_request(stim_rows[n].req);
            awaited_results.push_back(stim_rows[n].typed ? stim_rows[n].res : predicted);
        end
        t_now = 32'd3700;

        for (phase = 0; phase < PHASES; phase++) begin
            // Registers change only with the block idle: every result back, no request
            // in flight (each request yields exactly one result).
            s_axis_tvalid <= 1'b0;
            while (awaited_results.size() != 0) @(posedge i_clk);
            repeat (4) @(posedge i_clk);

            case (phase)
                0: begin
                    ver_sel = '0;
                    tmo_sel = '0;
                    win_sel = '0;
                end
                1: begin
                    ver_sel = '1;
                    tmo_sel = '1;
                    win_sel = '1;
                end
                default: begin
                    ver_sel = ($urandom_range(0, 1) != 0) ? 32'($urandom_range(0, 3)) : $urandom;
                    tmo_sel = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 400))
                                                          : 16'($urandom);
                    win_sel = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 400))
                                                          : 16'($urandom);
                end
            endcase
            // Upper bits of the 16-bit registers carry junk; it must be masked off.
            junk = $urandom;
            write_register(CFG_EXPECTED_VERSION, ver_sel);
            write_register(CFG_IDLE_TMO, {junk[31:16], tmo_sel});
            write_register(CFG_REPLAY_WINDOW, {junk[15:0], win_sel});
            if (phase % 2 == 1) write_register(CFG_SPARE, $urandom);
            i_cfg_valid <= 1'b0;

            // Phase 1 is authenticate-heavy with the longest timeout so the table
            // fills and full results appear; it also carries the long output stall.
            auth_pct      = (phase == 1) ? 85 : $urandom_range(35, 75);
            sender_steady = (phase == 2 || phase == 5);
            if (phase == 1) hold_request = 1'b1;
            if (phase > 1 && $urandom_range(0, 3) == 0) t_now = $urandom;

            for (item = 0; item < ITEMS_PER_PHASE; item++) begin
                // Advance the clock: mostly small steps, sometimes past the timeout,
                // exactly on it, or backwards.
                roll = $urandom_range(0, 99);
                if (roll < 15)      ;
                else if (roll < 65) t_now = t_now + $urandom_range(0, idle_limit / 16 + 1);
                else if (roll < 80) t_now = t_now + $urandom_range(0, idle_limit + 2);
                else if (roll < 88) t_now = t_now - $urandom_range(1, 40);
                else if (roll < 94) t_now = t_now + idle_limit + $urandom_range(1, 64);
                else                t_now = t_now + idle_limit;

                req.now = t_now;
                roll = $urandom_range(0, 99);
                if (roll < 8) begin
                    // Noise: every field random over its whole range.
                    req.action       = 1'($urandom_range(0, 1));
                    req.now          = $urandom;
                    req.req_version  = $urandom;
                    req.request_time = $urandom;
                    req.name_empty   = 1'($urandom_range(0, 1));
                    req.lookup_id    = $urandom;
                end else if ($urandom_range(0, 99) < auth_pct) begin
                    req.action      = ACT_AUTH;
                    req.req_version = ($urandom_range(0, 99) < 94) ? want_version : $urandom;
                    span = replay_span;
                    roll = $urandom_range(0, 99);
                    off  = (roll < 80) ? $urandom_range(0, span) : (roll < 90) ? span : span + 1;
                    req.request_time = ($urandom_range(0, 1) != 0) ? t_now + off : t_now - off;
                    req.name_empty   = ($urandom_range(0, 99) < 6);
                    req.lookup_id    = $urandom;
                end else begin
                    req.action       = ACT_VALIDATE;
                    req.req_version  = $urandom;
                    req.request_time = $urandom;
                    req.name_empty   = 1'($urandom_range(0, 1));
                    live_count = 0;
                    for (k = 0; k < SLOTS; k++) begin
                        if (live[k]) live_count++;
                    end
                    roll = $urandom_range(0, 99);
                    if (roll < 70 && live_count > 0) begin
                        // Look up a session that is currently open.
                        pick = $urandom_range(0, live_count - 1);
                        for (k = 0; k < SLOTS; k++) begin
                            if (live[k]) begin
                                if (pick == 0) req.lookup_id = held_id[k];
                                pick--;
                            end
                        end
                    end else if (roll < 82) begin
                        req.lookup_id = mdl_next_id - $urandom_range(1, 4);
                    end else if (roll < 88) begin
                        req.lookup_id = mdl_next_id;
                    end else if (roll < 94) begin
                        req.lookup_id = '0;
                    end else begin
                        req.lookup_id = $urandom;
                    end
                end

                send_request(req);
                awaited_results.push_back(serve_request(req));
            end
        end

        s_axis_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        // Room for a stray extra result from a full-table scan to show up.
        repeat (SLOTS + 8) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("session_table_with_expiry_core_tb passed");
        end else begin
            $display("session_table_with_expiry_core_tb failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
src/stwe_pkg.sv
src/stwe_ram.sv
src/stwe_ctrl.sv
src/session_table_with_expiry_core.sv
tb/session_table_with_expiry_core_tb.sv
